/* hdl/cgi_response_header_scanner_core_defines.svh */
// ----------------------------------------------------------------------------
// cgi response header scanner assertion macros
// concurrent check helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef CGI_RESPONSE_HEADER_SCANNER_CORE_DEFINES_SVH
`define CGI_RESPONSE_HEADER_SCANNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CGI_HDR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cgi_hdr check failed");
`define CGI_HDR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cgi_hdr check failed");
`else
`define CGI_HDR_ASSERT(lbl, prop)
`define CGI_HDR_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

/* hdl/cgi_hdr_pkg.sv */
// ----------------------------------------------------------------------------
// cgi_hdr_pkg
// shared types, codes and byte constants of the cgi response header scanner
// ----------------------------------------------------------------------------
package cgi_hdr_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int OUT_POS_W    = 16;
    localparam int CODE_W       = 3;

    localparam int STATUS_NAME_LEN   = 6;
    localparam int LOCATION_NAME_LEN = 8;

    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;

    localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
    localparam logic [CODE_W-1:0] CODE_200  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_301  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_302  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_303  = 3'd4;

    typedef enum logic [12:0] {
        ST_START       = 13'b0000000000001,
        ST_CRLF        = 13'b0000000000010,
        ST_CR          = 13'b0000000000100,
        ST_CRLF_CR     = 13'b0000000001000,
        ST_S           = 13'b0000000010000,
        ST_STAT_COLON  = 13'b0000000100000,
        ST_STAT_3XX    = 13'b0000001000000,
        ST_STAT_FOUND  = 13'b0000010000000,
        ST_L           = 13'b0000100000000,
        ST_LOC_COLON   = 13'b0001000000000,
        ST_LOC_VALUE   = 13'b0010000000000,
        ST_OTHER       = 13'b0100000000000,
        ST_DONE        = 13'b1000000000000
    } scan_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                  location_flag;
        logic                  location_end;
        logic                  body_flag;
        logic                  header_done;
        logic                  parse_fail;
        logic [CODE_W-1:0]     status_code;
        logic                  strip_valid;
        logic [OUT_POS_W-1:0]  strip_begin;
        logic [OUT_POS_W-1:0]  strip_end;
        logic                  result_last;
    } out_item_t;

endpackage

/* hdl/cgi_response_header_scanner_core.sv */
// ----------------------------------------------------------------------------
// cgi_response_header_scanner_core
// Byte-wise scanner of a cgi response header.
// req channel (req_valid/req_ready/req_item) takes one response byte per
// item with first_byte and last_byte marks; rsp channel
// (rsp_valid/rsp_ready/rsp_item) returns exactly one result item per byte,
// in order: location and body flags, header end, parse failure, status code
// and the strip range of the Status line.
// An accepted byte is held in the input register, is scanned by the
// state logic and lands in the result register, which drives rsp_valid.
// One byte per cycle is sustained while rsp_ready stays high; the rate is
// set by the scan logic, which updates its state once for every byte.
// Reset clears the valid bits of both registers and the parse state;
// first_byte also restarts the scan. When rsp_ready is low the result holds,
// the input register still takes one more byte, and req_ready then drops until rsp moves.
// ----------------------------------------------------------------------------
module cgi_response_header_scanner_core
    import cgi_hdr_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  in_item_t  req_item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_item_t rsp_item
);

`include "cgi_response_header_scanner_core_defines.svh"

    logic      in_vld_reg;
    in_item_t  in_item_reg;
    logic      out_vld_reg;
    out_item_t out_item_reg;
    out_item_t scan_result;
    logic      advance;

    assign advance   = in_vld_reg && (!out_vld_reg || rsp_ready);
    assign req_ready = !in_vld_reg || advance;
    assign rsp_valid = out_vld_reg;
    assign rsp_item  = out_item_reg;

    cgi_hdr_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (scan_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                in_vld_reg <= req_valid;
            if (!out_vld_reg || rsp_ready)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            in_item_reg <= req_item;
        if (advance)
            out_item_reg <= scan_result;
    end

    // result field relations
    `CGI_HDR_ASSERT_IMP(a_done_has_code, rsp_valid && rsp_item.header_done, rsp_item.status_code != CODE_NONE)
    `CGI_HDR_ASSERT_IMP(a_body_not_done, rsp_valid && rsp_item.body_flag, !rsp_item.header_done && !rsp_item.parse_fail)
    `CGI_HDR_ASSERT_IMP(a_strip_after_end, rsp_valid && rsp_item.strip_valid, rsp_item.header_done || rsp_item.body_flag)
    `CGI_HDR_ASSERT_IMP(a_fail_on_last, rsp_valid && rsp_item.parse_fail, rsp_item.result_last)
    // a scanned byte always reaches the result register next cycle
    `CGI_HDR_ASSERT_IMP(a_advance_fills, advance, ##1 out_vld_reg)

endmodule

/* hdl/cgi_hdr_scan.sv */
// ----------------------------------------------------------------------------
// cgi_hdr_scan
// parse state and per-byte next-state logic; state advances on step
// ----------------------------------------------------------------------------
module cgi_hdr_scan
    import cgi_hdr_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result
);

    localparam logic [POS_BITS-1:0] STATUS_DIST   = POS_BITS'(STATUS_NAME_LEN);
    localparam logic [POS_BITS-1:0] LOCATION_DIST = POS_BITS'(LOCATION_NAME_LEN);
    localparam logic [POS_BITS-1:0] POS_ONE       = POS_BITS'(1);

    scan_state_t         state_reg, state_next, state_cur;
    logic [CODE_W-1:0]   status_reg, status_next, status_cur;
    logic [POS_BITS-1:0] token_reg, token_next, token_cur;
    logic [7:0]          prior_reg, prior_cur;
    logic [POS_BITS-1:0] pos_reg, pos_cur;
    logic [POS_BITS-1:0] first_reg, first_next, first_cur;
    logic [POS_BITS-1:0] last_reg, last_next, last_cur;
    logic                last_set_reg, last_set_next, last_set_cur;
    logic [POS_BITS-1:0] name_gap;
    logic [7:0]          b;
    logic                loc_flag, loc_end, body, done;
    logic [CODE_W-1:0]   code;
    logic                svalid;

    // first_byte restarts the scan from the reset values
    always_comb
    begin
        if (item.first_byte)
        begin
            state_cur    = ST_START;
            status_cur   = CODE_NONE;
            token_cur    = '0;
            prior_cur    = '0;
            pos_cur      = '0;
            first_cur    = '0;
            last_cur     = '0;
            last_set_cur = 1'b0;
        end
        else
        begin
            state_cur    = state_reg;
            status_cur   = status_reg;
            token_cur    = token_reg;
            prior_cur    = prior_reg;
            pos_cur      = pos_reg;
            first_cur    = first_reg;
            last_cur     = last_reg;
            last_set_cur = last_set_reg;
        end
    end

    assign b        = item.data_byte;
    assign name_gap = pos_cur - token_cur;

    always_comb
    begin
        state_next    = state_cur;
        status_next   = status_cur;
        token_next    = token_cur;
        first_next    = first_cur;
        last_next     = last_cur;
        last_set_next = last_set_cur;
        loc_flag      = 1'b0;
        loc_end       = 1'b0;
        body          = 1'b0;
        done          = 1'b0;
        case (state_cur)
            ST_START, ST_CRLF:
            begin
                if (b == CH_S)
                begin
                    state_next = ST_S;
                    token_next = pos_cur;
                end
                else if (b == CH_L)
                begin
                    state_next = ST_L;
                    token_next = pos_cur;
                end
                else if (b == CH_CR)
                    state_next = (state_cur == ST_CRLF) ? ST_CRLF_CR : ST_CR;
                else
                    state_next = ST_OTHER;
            end
            ST_S:
            begin
                if (b == CH_COLON)
                begin
                    if (name_gap == STATUS_DIST)
                    begin
                        first_next = pos_cur - STATUS_DIST;
                        state_next = ST_STAT_COLON;
                    end
                    else
                        state_next = ST_OTHER;
                end
            end
            ST_STAT_COLON:
            begin
                if (b == CH_TWO)
                begin
                    status_next = CODE_200;
                    state_next  = ST_STAT_FOUND;
                end
                else if (b == CH_THREE)
                    state_next = ST_STAT_3XX;
            end
            ST_STAT_3XX:
            begin
                if (b == CH_SPACE)
                begin
                    if (prior_cur == CH_ONE)
                    begin
                        status_next = CODE_301;
                        state_next  = ST_STAT_FOUND;
                    end
                    else if (prior_cur == CH_TWO)
                    begin
                        status_next = CODE_302;
                        state_next  = ST_STAT_FOUND;
                    end
                    else if (prior_cur == CH_THREE)
                    begin
                        status_next = CODE_303;
                        state_next  = ST_STAT_FOUND;
                    end
                    else
                        state_next = ST_OTHER;
                end
            end
            ST_STAT_FOUND:
            begin
                if (b == CH_CR)
                begin
                    if (!item.last_byte)
                    begin
                        last_next     = pos_cur + POS_ONE;
                        last_set_next = 1'b1;
                    end
                    state_next = ST_CR;
                end
            end
            ST_L:
            begin
                if (b == CH_COLON)
                    state_next = (name_gap == LOCATION_DIST) ? ST_LOC_COLON : ST_OTHER;
            end
            ST_LOC_COLON:
            begin
                if (b != CH_SPACE)
                begin
                    token_next = pos_cur;
                    loc_flag   = 1'b1;
                    state_next = ST_LOC_VALUE;
                end
            end
            ST_LOC_VALUE:
            begin
                if (b == CH_CR)
                begin
                    loc_end    = 1'b1;
                    state_next = ST_CR;
                end
                else
                    loc_flag = 1'b1;
            end
            ST_CR:
            begin
                if (b == CH_LF)
                    state_next = ST_CRLF;
            end
            ST_CRLF_CR:
            begin
                if (b == CH_LF)
                begin
                    done       = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
                body = 1'b1;
            default:
            begin
                if (b == CH_CR)
                    state_next = ST_CR;
            end
        endcase
    end

    always_comb
    begin
        code   = status_next;
        svalid = 1'b0;
        if (state_next == ST_DONE)
        begin
            if (status_next == CODE_NONE)
                code = CODE_200;
            svalid = (status_next != CODE_NONE) && last_set_next;
        end
    end

    assign result.location_flag = loc_flag;
    assign result.location_end  = loc_end;
    assign result.body_flag     = body;
    assign result.header_done   = done;
    assign result.parse_fail    = item.last_byte && (state_next != ST_DONE);
    assign result.status_code   = code;
    assign result.strip_valid   = svalid;
    assign result.strip_begin   = OUT_POS_W'(first_next);
    assign result.strip_end     = OUT_POS_W'(last_next);
    assign result.result_last   = item.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_START;
            status_reg   <= CODE_NONE;
            token_reg    <= '0;
            prior_reg    <= '0;
            pos_reg      <= '0;
            first_reg    <= '0;
            last_reg     <= '0;
            last_set_reg <= 1'b0;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            token_reg    <= token_next;
            prior_reg    <= b;
            pos_reg      <= pos_cur + POS_ONE;
            first_reg    <= first_next;
            last_reg     <= last_next;
            last_set_reg <= last_set_next;
        end
    end

endmodule
